// ----- sv/hegr_pkg.sv -----
package hegr_pkg;

	// Buffer and decoder sizing
	localparam int BUFFER_BYTES     = 16;
	localparam int MAX_READ_BITS    = 64;
	localparam int MAX_PREFIX_ZEROS = 31;

	// Fixed field widths
	localparam int OP_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 7;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int AVAIL_W  = 8;

	// Derived sizes
	localparam int TOTAL_BITS   = BUFFER_BYTES * 8;
	localparam int POS_W        = $clog2(TOTAL_BITS);
	localparam int FILL_W       = $clog2(TOTAL_BITS + 1);
	localparam int IDX_W        = $clog2(BUFFER_BYTES);
	localparam int ARITH_W      = FILL_W + 1;
	localparam int N_W          = $clog2(MAX_READ_BITS + 1);
	localparam int PREFIX_LIMIT = MAX_PREFIX_ZEROS + 1;
	localparam int LZ_W         = $clog2(PREFIX_LIMIT + 1);
	localparam int UE_BITS      = 2 * MAX_PREFIX_ZEROS + 1;
	localparam int WIN_W        = (MAX_READ_BITS > UE_BITS) ? MAX_READ_BITS : UE_BITS;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_READ_U = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_S = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
	localparam logic [OP_W-1:0] OP_UE     = 3'd4;
	localparam logic [OP_W-1:0] OP_SE     = 3'd5;
	localparam logic [OP_W-1:0] OP_SKIP   = 3'd6;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

endpackage

// ----- sv/hegr_if.sv -----
// Request channel: one bitstream operation per transaction.
interface hegr_req_if;
	logic                        valid;
	logic                        ready;
	logic [hegr_pkg::OP_W-1:0]   opcode;
	logic [hegr_pkg::BYTE_W-1:0] byte_in;
	logic [hegr_pkg::CNT_W-1:0]  bit_count;

	modport source (output valid, output opcode, output byte_in, output bit_count,
		input ready);
	modport sink (input valid, input opcode, input byte_in, input bit_count,
		output ready);
endinterface

// Response channel: one result per request.
interface hegr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [hegr_pkg::VALUE_W-1:0]  value;
	logic [hegr_pkg::STATUS_W-1:0] status;
	logic [hegr_pkg::AVAIL_W-1:0]  bits_available;

	modport source (output valid, output value, output status, output bits_available,
		input ready);
	modport sink (input valid, input value, input status, input bits_available,
		output ready);
endinterface

// ----- sv/h264_bitstream_exp_golomb_reader.sv -----
// MSB-first H.264 RBSP bit reader. Each request transaction (push a byte, read or
// peek up to 64 bits, signed read, ue(v), se(v), skip) yields exactly one response
// transaction, in order. A request sits in the input register, is decoded in a
// single pass (a rotate of the 16-byte circular store to the read position, a
// 32-bit leading-zero count and a suffix shift), and its result lands in the output
// register, which raises response valid and holds the result until the response
// side takes it. One request is accepted every cycle as long as the response side
// keeps taking results. The buffer state updates when a request leaves the input
// register, so back-to-back requests always see the effect of the one before. A
// failing read, ue or se (underflow or a prefix of 32 zeros) consumes nothing; a
// push into a full store is dropped with status 2. bits_available reports the
// unread bit count after each request.
module h264_bitstream_exp_golomb_reader (
	input  logic       clk,
	input  logic       arst_n,
	hegr_req_if.sink   req,
	hegr_rsp_if.source rsp
);

	localparam int TB = hegr_pkg::TOTAL_BITS;
	localparam int AW = hegr_pkg::ARITH_W;

	// Input register
	logic                        v_s1;
	logic [hegr_pkg::OP_W-1:0]   op_s1;
	logic [hegr_pkg::BYTE_W-1:0] byte_s1;
	logic [hegr_pkg::CNT_W-1:0]  cnt_s1;

	// Output register
	logic                          v_s2;
	logic [hegr_pkg::VALUE_W-1:0]  value_s2;
	logic [hegr_pkg::STATUS_W-1:0] status_s2;
	logic [hegr_pkg::AVAIL_W-1:0]  avail_s2;

	// Buffer state
	logic [7:0]                  store_q [hegr_pkg::BUFFER_BYTES];
	logic [hegr_pkg::POS_W-1:0]  pos_q;
	logic [hegr_pkg::FILL_W-1:0] fill_q;

	logic adv_s2;
	logic fire_s1;

	// Advance the output register when it is empty or being drained; advance the
	// input register into it in the same cycle.
	assign adv_s2    = !v_s2 || rsp.ready;
	assign fire_s1   = v_s1 && adv_s2;
	assign req.ready = !v_s1 || adv_s2;

	// Window onto the store, starting at the next unread bit.
	logic [TB-1:0]                store_flat;
	logic [2*TB-1:0]              store_dbl;
	logic [hegr_pkg::WIN_W-1:0]   win;

	always_comb begin
		for (int i = 0; i < hegr_pkg::BUFFER_BYTES; i++) begin
			store_flat[TB-1-8*i -: 8] = store_q[i];
		end
		store_dbl = {store_flat, store_flat} << pos_q;
		win       = store_dbl[2*TB-1 -: hegr_pkg::WIN_W];
	end

	// Fixed-count read path: clamp, right-align, optional sign extension.
	logic [hegr_pkg::N_W-1:0]           n;
	logic [hegr_pkg::N_W-1:0]           rd_shift;
	logic [hegr_pkg::MAX_READ_BITS-1:0] rd_top;
	logic [hegr_pkg::VALUE_W-1:0]       rd_val;
	logic [hegr_pkg::VALUE_W-1:0]       ext_mask;
	logic                               rd_sign;
	logic [hegr_pkg::VALUE_W-1:0]       rd_sval;

	always_comb begin
		n = (cnt_s1 > hegr_pkg::CNT_W'(hegr_pkg::MAX_READ_BITS))
			? hegr_pkg::N_W'(hegr_pkg::MAX_READ_BITS) : hegr_pkg::N_W'(cnt_s1);
		rd_shift = hegr_pkg::N_W'(hegr_pkg::MAX_READ_BITS) - n;
		rd_top   = win[hegr_pkg::WIN_W-1 -: hegr_pkg::MAX_READ_BITS];
		rd_val   = hegr_pkg::VALUE_W'(rd_top) >> rd_shift;
		// ext_mask covers bits n and up; its complement ANDed with the mask shifted
		// down one isolates bit n-1, the sign bit. A full-width read needs no extension.
		ext_mask = ~hegr_pkg::VALUE_W'(0) << n;
		rd_sign  = |(rd_val & ~ext_mask & (ext_mask >> 1));
		rd_sval  = rd_sign ? (rd_val | ext_mask) : rd_val;
	end

	// Exp-Golomb path: leading-zero count over the first PREFIX_LIMIT bits, then
	// the suffix of the same length just past the terminating one.
	logic [hegr_pkg::PREFIX_LIMIT-1:0] prefix;
	logic [hegr_pkg::LZ_W-1:0]         lz;
	logic [AW-1:0]                     lz_eff;
	logic                              ue_bad;
	logic                              ue_under;
	logic [hegr_pkg::WIN_W-1:0]        suf_win;
	logic [hegr_pkg::VALUE_W-1:0]      suffix;
	logic [hegr_pkg::VALUE_W-1:0]      code;
	logic [hegr_pkg::VALUE_W-1:0]      se_val;

	always_comb begin
		prefix = win[hegr_pkg::WIN_W-1 -: hegr_pkg::PREFIX_LIMIT];
		lz     = hegr_pkg::LZ_W'(hegr_pkg::PREFIX_LIMIT);
		for (int i = 0; i < hegr_pkg::PREFIX_LIMIT; i++) begin
			if (prefix[i]) begin
				lz = hegr_pkg::LZ_W'(hegr_pkg::PREFIX_LIMIT - 1 - i);
			end
		end
		// The count stops at the end of the buffered bits.
		lz_eff = (AW'(lz) > AW'(fill_q)) ? AW'(fill_q) : AW'(lz);
		ue_bad   = lz_eff >= AW'(hegr_pkg::PREFIX_LIMIT);
		ue_under = (lz_eff >= AW'(fill_q)) || (AW'(fill_q) < ((lz_eff << 1) + AW'(1)));
		suf_win  = win << (lz + hegr_pkg::LZ_W'(1));
		suffix   = hegr_pkg::VALUE_W'(suf_win) >> (hegr_pkg::WIN_W - int'(lz));
		code     = (hegr_pkg::VALUE_W'(1) << lz) - hegr_pkg::VALUE_W'(1) + suffix;
		se_val   = code[0] ? ((code >> 1) + hegr_pkg::VALUE_W'(1))
			: (hegr_pkg::VALUE_W'(0) - (code >> 1));
	end

	// Per-request decision: result fields, bits consumed, byte write.
	logic [hegr_pkg::VALUE_W-1:0]  res_value;
	logic [hegr_pkg::STATUS_W-1:0] res_status;
	logic [AW-1:0]                 consume;
	logic                          push_en;
	logic [AW-1:0]                 wsum;
	logic [AW-1:0]                 wpos_full;
	logic [hegr_pkg::POS_W-1:0]    wpos;
	logic [AW-1:0]                 psum;
	logic [AW-1:0]                 pos_wrap;
	logic [hegr_pkg::POS_W-1:0]    pos_next;
	logic [hegr_pkg::FILL_W-1:0]   fill_next;

	always_comb begin
		res_value  = '0;
		res_status = hegr_pkg::ST_OK;
		consume    = '0;
		push_en    = 1'b0;
		fill_next  = fill_q;

		unique case (op_s1) inside
			hegr_pkg::OP_PUSH: begin
				if (AW'(fill_q) + AW'(8) > AW'(TB)) begin
					res_status = hegr_pkg::ST_FULL;
				end else begin
					push_en   = 1'b1;
					fill_next = fill_q + hegr_pkg::FILL_W'(8);
				end
			end
			hegr_pkg::OP_READ_U, hegr_pkg::OP_READ_S, hegr_pkg::OP_PEEK: begin
				if (AW'(fill_q) < AW'(n)) begin
					res_status = hegr_pkg::ST_UNDER;
				end else begin
					res_value = (op_s1 == hegr_pkg::OP_READ_S) ? rd_sval : rd_val;
					if (op_s1 != hegr_pkg::OP_PEEK) begin
						consume = AW'(n);
					end
				end
			end
			hegr_pkg::OP_UE, hegr_pkg::OP_SE: begin
				if (ue_bad) begin
					res_status = hegr_pkg::ST_BAD;
				end else if (ue_under) begin
					res_status = hegr_pkg::ST_UNDER;
				end else begin
					res_value = (op_s1 == hegr_pkg::OP_SE) ? se_val : code;
					consume   = (AW'(lz) << 1) + AW'(1);
				end
			end
			hegr_pkg::OP_SKIP: begin
				if (AW'(fill_q) < AW'(cnt_s1)) begin
					res_status = hegr_pkg::ST_UNDER;
				end else begin
					consume = AW'(cnt_s1);
				end
			end
			default: begin
				// Unknown opcode: no effect.
			end
		endcase

		if (op_s1 != hegr_pkg::OP_PUSH) begin
			fill_next = fill_q - hegr_pkg::FILL_W'(consume);
		end

		// Write position and new read position, both modulo the store size in bits.
		wsum      = AW'(pos_q) + AW'(fill_q);
		wpos_full = (wsum >= AW'(TB)) ? (wsum - AW'(TB)) : wsum;
		wpos      = hegr_pkg::POS_W'(wpos_full);
		psum      = AW'(pos_q) + consume;
		pos_wrap  = (psum >= AW'(TB)) ? (psum - AW'(TB)) : psum;
		pos_next  = hegr_pkg::POS_W'(pos_wrap);
	end

	// Input register: take a transaction whenever there is room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.opcode;
			byte_s1 <= req.byte_in;
			cnt_s1  <= req.bit_count;
		end
	end

	// Buffer state: advance as each request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (fire_s1) begin
			pos_q  <= pos_next;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && push_en) begin
			store_q[wpos[hegr_pkg::POS_W-1:3]] <= byte_s1;
		end
	end

	// Output register: hold the result until the response transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			value_s2  <= res_value;
			status_s2 <= res_status;
			avail_s2  <= hegr_pkg::AVAIL_W'(fill_next);
		end
	end

	assign rsp.valid          = v_s2;
	assign rsp.value          = value_s2;
	assign rsp.status         = status_s2;
	assign rsp.bits_available = avail_s2;

endmodule
